@@ design/kmp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

	// Pattern store depth and the widths that follow from it
	localparam int MAX_PATTERN = 64;
	localparam int PLEN_W      = $clog2(MAX_PATTERN + 1);

	// Fixed field widths
	localparam int OP_W    = 2;
	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 8;
	localparam int SIZE_W  = 7;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
	localparam logic [OP_W-1:0] OP_TEXT    = 2'd2;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

	// Stop count after reset
	localparam logic [COUNT_W-1:0] STOP_COUNT_RESET = 8'd2;

	// Per-cycle commands broadcast along the cell row
	typedef struct packed {
		logic clear_pattern;
		logic reset_match;
		logic load;
		logic step;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/kmp_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One pattern position: its character, its valid bit and one bit of the
// active-prefix set (set when the prefix ending at this position is a
// suffix of the text seen so far).
module kmp_cell (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  kmp_pkg::cell_ctrl_t      ctrl,
	input  wire  [kmp_pkg::CHAR_W-1:0]     char_in,
	input  wire                            prev_active,
	input  wire                            prev_valid,
	input  wire                            next_valid,
	output logic                           active,
	output logic                           valid,
	output logic                           hit
);

	logic [kmp_pkg::CHAR_W-1:0] char_q;
	logic                       valid_q;
	logic                       active_q;
	logic                       extend;
	logic                       load_here;

	// Extend the prefix handed over by the left neighbor
	assign extend    = prev_active & valid_q & (char_q == char_in);
	// Load into the first empty position of the row
	assign load_here = ctrl.load & prev_valid & ~valid_q;
	// Full occurrence when the extended prefix ends at the last position
	assign hit       = extend & ~next_valid;

	assign active = active_q;
	assign valid  = valid_q;

	// Hold the pattern character
	always_ff @(posedge clk) begin
		if (load_here) begin
			char_q <= char_in;
		end
	end

	// Track occupancy and the active-prefix bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			active_q <= 1'b0;
		end else begin
			if (ctrl.clear_pattern) begin
				valid_q <= 1'b0;
			end else if (load_here) begin
				valid_q <= 1'b1;
			end
			if (ctrl.clear_pattern || ctrl.reset_match) begin
				active_q <= 1'b0;
			end else if (ctrl.step) begin
				active_q <= extend;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/kmp_cell_row.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Row of pattern cells. Each cell passes its active bit and its valid bit
// to its neighbors; the empty prefix always feeds the head of the row.
module kmp_cell_row (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  kmp_pkg::cell_ctrl_t      ctrl,
	input  wire  [kmp_pkg::CHAR_W-1:0]     char_in,
	output logic                           row_hit
);

	localparam int N = kmp_pkg::MAX_PATTERN;

	logic [N-1:0] active_vec;
	logic [N-1:0] valid_vec;
	logic [N-1:0] hit_vec;
	logic [N-1:0] prev_active_vec;
	logic [N-1:0] prev_valid_vec;
	logic [N-1:0] next_valid_vec;

	// Chain the neighbor links
	assign prev_active_vec = {active_vec[N-2:0], 1'b1};
	assign prev_valid_vec  = {valid_vec[N-2:0], 1'b1};
	assign next_valid_vec  = {1'b0, valid_vec[N-1:1]};

	for (genvar i = 0; i < N; i++) begin : g_cell
		kmp_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.char_in     (char_in),
			.prev_active (prev_active_vec[i]),
			.prev_valid  (prev_valid_vec[i]),
			.next_valid  (next_valid_vec[i]),
			.active      (active_vec[i]),
			.valid       (valid_vec[i]),
			.hit         (hit_vec[i])
		);
	end

	// Collect the occurrence flag
	assign row_hit = |hit_vec;

endmodule

`default_nettype wire

@@ design/kmp_stream_matcher_top.sv @@
// Streaming pattern matcher.
// Input channel (in_valid/in_ready): one word carries an operation and a byte:
//   clear pattern, append pattern byte, text byte, or restart the search.
// Output channel (out_valid/out_ready): exactly one result word per input
//   word, in order: match_end, match_total, count_reached, pattern_size,
//   overflow_error.
// Configuration: cfg_we writes cfg_wdata into the stop count (reset value 2);
//   write it only while no word is in flight.
// Result: registered; it appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output register is drained. Every
//   pattern position is a cell that compares the text byte in parallel and hands
//   its prefix bit to its neighbor, so no fallback chain is walked.
// Stalls: a single output register holds the result; a new word is taken in
//   the cycle that register is empty or being drained, so in_ready follows
//   out_ready while a result waits.
// Reset (arst_n low): pattern empty, search state and count cleared, stop
//   count back to 2, no result pending. Stored pattern characters are not
//   cleared; positions past the pattern length are never consulted.
`timescale 1ns / 1ps
`default_nettype none

module kmp_stream_matcher_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [kmp_pkg::COUNT_W-1:0]      cfg_wdata,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [kmp_pkg::OP_W-1:0]         operation,
	input  wire  [kmp_pkg::CHAR_W-1:0]       data_byte,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic                             match_end,
	output logic [kmp_pkg::COUNT_W-1:0]      match_total,
	output logic                             count_reached,
	output logic [kmp_pkg::SIZE_W-1:0]       pattern_size,
	output logic                             overflow_error
);

	logic [kmp_pkg::COUNT_W-1:0] stop_count_q;
	logic [kmp_pkg::COUNT_W-1:0] hit_count_q;
	logic [kmp_pkg::PLEN_W-1:0]  len_q;
	logic                        out_valid_q;
	logic                        match_end_q;
	logic [kmp_pkg::COUNT_W-1:0] match_total_q;
	logic                        count_reached_q;
	logic [kmp_pkg::PLEN_W-1:0]  pattern_size_q;
	logic                        overflow_error_q;

	logic                        accept;
	logic                        full;
	logic                        empty;
	logic                        reached;
	logic                        row_hit;
	logic                        match;
	logic                        overflow;
	logic [kmp_pkg::COUNT_W-1:0] count_next;
	logic [kmp_pkg::PLEN_W-1:0]  len_next;
	kmp_pkg::cell_ctrl_t         ctrl;

	assign in_ready = ~out_valid_q | out_ready;
	assign accept   = in_valid & in_ready;

	assign full    = (len_q == kmp_pkg::PLEN_W'(kmp_pkg::MAX_PATTERN));
	assign empty   = (len_q == '0);
	assign reached = (hit_count_q >= stop_count_q);

	// Decode the accepted word into row commands
	always_comb begin
		ctrl = '0;
		if (accept) begin
			case (operation)
				kmp_pkg::OP_CLEAR:   ctrl.clear_pattern = 1'b1;
				kmp_pkg::OP_APPEND:  ctrl.load          = ~full;
				kmp_pkg::OP_TEXT:    ctrl.step          = ~empty & ~reached;
				kmp_pkg::OP_RESTART: ctrl.reset_match   = 1'b1;
				default:             ctrl = '0;
			endcase
		end
	end

	kmp_cell_row u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.char_in (data_byte),
		.row_hit (row_hit)
	);

	assign match    = ctrl.step & row_hit;
	assign overflow = (operation == kmp_pkg::OP_APPEND) & full;

	// Work out count and length after the word
	always_comb begin
		count_next = hit_count_q;
		len_next   = len_q;
		case (operation)
			kmp_pkg::OP_CLEAR: begin
				count_next = '0;
				len_next   = '0;
			end
			kmp_pkg::OP_APPEND: begin
				if (!full) begin
					len_next = kmp_pkg::PLEN_W'(len_q + 1'b1);
				end
			end
			kmp_pkg::OP_TEXT: begin
				if (match) begin
					count_next = kmp_pkg::COUNT_W'(hit_count_q + 1'b1);
				end
			end
			kmp_pkg::OP_RESTART: begin
				count_next = '0;
			end
			default: begin
				count_next = hit_count_q;
			end
		endcase
	end

	// Hold the stop count, pattern length and match count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q <= kmp_pkg::STOP_COUNT_RESET;
			hit_count_q  <= '0;
			len_q        <= '0;
		end else begin
			if (cfg_we) begin
				stop_count_q <= cfg_wdata;
			end
			if (accept) begin
				hit_count_q <= count_next;
				len_q       <= len_next;
			end
		end
	end

	// Advance the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			match_end_q      <= match;
			match_total_q    <= count_next;
			count_reached_q  <= (count_next >= stop_count_q);
			pattern_size_q   <= len_next;
			overflow_error_q <= overflow;
		end
	end

	assign out_valid      = out_valid_q;
	assign match_end      = match_end_q;
	assign match_total    = match_total_q;
	assign count_reached  = count_reached_q;
	assign pattern_size   = kmp_pkg::SIZE_W'(pattern_size_q);
	assign overflow_error = overflow_error_q;

	// Length never exceeds the store
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= kmp_pkg::PLEN_W'(kmp_pkg::MAX_PATTERN))
		else $error("pattern length beyond store depth");

	// A reported occurrence is always counted
	a_match_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && match_end_q |-> match_total_q != '0)
		else $error("occurrence reported with zero count");

	// Overflow only on a full store
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && overflow_error_q |->
		pattern_size_q == kmp_pkg::PLEN_W'(kmp_pkg::MAX_PATTERN))
		else $error("overflow reported below capacity");

	// A clear empties the pattern and the count
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == kmp_pkg::OP_CLEAR |=> len_q == '0 && hit_count_q == '0)
		else $error("clear left pattern or count");

	// No text match without a loaded pattern
	a_match_needs_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		match |-> !empty)
		else $error("match on empty pattern");

endmodule

`default_nettype wire

@@ verif/kmp_stream_matcher_top_tb.sv @@
`timescale 1ns / 1ps

module kmp_stream_matcher_top_tb;

	typedef struct packed {
		logic [kmp_pkg::OP_W-1:0]   op;
		logic [kmp_pkg::CHAR_W-1:0] data;
	} match_word_t;

	typedef struct packed {
		logic                        match_end;
		logic [kmp_pkg::COUNT_W-1:0] match_total;
		logic                        count_reached;
		logic [kmp_pkg::SIZE_W-1:0]  pattern_size;
		logic                        overflow_error;
	} match_result_t;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	localparam int HOLD_LEN       = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRESSURE_PHASE = 3;

	logic                        clk            = 1'b0;
	logic                        arst_n         = 1'b0;
	logic                        cfg_we         = 1'b0;
	logic [kmp_pkg::COUNT_W-1:0] cfg_wdata      = '0;
	logic                        in_valid       = 1'b0;
	logic [kmp_pkg::OP_W-1:0]    operation      = '0;
	logic [kmp_pkg::CHAR_W-1:0]  data_byte      = '0;
	logic                        out_ready      = 1'b1;
	logic                        in_ready;
	logic                        out_valid;
	logic                        match_end;
	logic [kmp_pkg::COUNT_W-1:0] match_total;
	logic                        count_reached;
	logic [kmp_pkg::SIZE_W-1:0]  pattern_size;
	logic                        overflow_error;

	kmp_stream_matcher_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_end      (match_end),
		.match_total    (match_total),
		.count_reached  (count_reached),
		.pattern_size   (pattern_size),
		.overflow_error (overflow_error)
	);

	// Predicted matcher state
	logic [kmp_pkg::CHAR_W-1:0] pat_chars [kmp_pkg::MAX_PATTERN];
	logic [kmp_pkg::SIZE_W-1:0] fail_len [kmp_pkg::MAX_PATTERN];
	int pat_len    = 0;
	int match_len  = 0;
	int hits       = 0;
	int stop_limit = kmp_pkg::STOP_COUNT_RESET;

	match_word_t   pending_words [$];
	match_result_t expected_results [$];
	int            pushed_words   = 0;
	int            mismatch_count = 0;
	idle_mode_t    idle_mode      = IDLE_NONE;
	int            phase_id       = 0;
	logic          word_taken     = 1'b0;
	bit            hold_done      = 1'b0;
	int            hold_cycles    = 0;
	int            quiet_cycles   = 0;

	// Clock: 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Advance the predicted matcher by one word and return its result
	function automatic match_result_t step_matcher(logic [kmp_pkg::OP_W-1:0] op,
			logic [kmp_pkg::CHAR_W-1:0] c);
		match_result_t r;
		int k;
		r = '0;
		case (op)
			kmp_pkg::OP_CLEAR: begin
				pat_len = 0;
				match_len = 0;
				hits = 0;
			end
			kmp_pkg::OP_APPEND: begin
				if (pat_len < kmp_pkg::MAX_PATTERN) begin
					k = 0;
					if (pat_len > 0) begin
						k = fail_len[pat_len - 1];
						while (k > 0 && pat_chars[k] != c)
							k = fail_len[k - 1];
						if (pat_chars[k] == c)
							k++;
					end
					pat_chars[pat_len] = c;
					fail_len[pat_len] = k[kmp_pkg::SIZE_W-1:0];
					pat_len++;
				end else begin
					r.overflow_error = 1'b1;
				end
			end
			kmp_pkg::OP_TEXT: begin
				if (pat_len != 0 && hits < stop_limit) begin
					k = match_len;
					if (k > pat_len)
						k = 0;
					// follow the fallback chain until the next byte can extend
					while (k > 0 && (k == pat_len || pat_chars[k] != c))
						k = fail_len[k - 1];
					if (pat_chars[k] == c)
						k++;
					match_len = k;
					if (k == pat_len) begin
						hits++;
						r.match_end = 1'b1;
					end
				end
			end
			default: begin
				match_len = 0;
				hits = 0;
			end
		endcase
		r.match_total = hits[kmp_pkg::COUNT_W-1:0];
		r.count_reached = (hits >= stop_limit);
		r.pattern_size = pat_len[kmp_pkg::SIZE_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Predict accepted words, check accepted results
	always @(posedge clk) begin
		match_result_t want;
		if (arst_n) begin
			word_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				expected_results.push_back(step_matcher(operation, data_byte));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result word: expected none actual %0d/%0d", $time,
						match_end, match_total);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("match_end", 8'(want.match_end), 8'(match_end));
					check_field("match_total", want.match_total, match_total);
					check_field("count_reached", 8'(want.count_reached), 8'(count_reached));
					check_field("pattern_size", 8'(want.pattern_size), 8'(pattern_size));
					check_field("overflow_error", 8'(want.overflow_error),
						8'(overflow_error));
				end
			end
		end
	end

	// Drive input words from the pending queue, idling at random
	always @(negedge clk) begin
		match_word_t w;
		int send_pct;
		send_pct = (idle_mode == IDLE_SEND) ? 62 : (idle_mode == IDLE_BOTH) ? 28 : 0;
		if (arst_n && (!in_valid || word_taken)) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				operation <= w.op;
				data_byte <= w.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Drive out_ready; hold off for a long stretch once in the pressure phase
	always @(negedge clk) begin
		int recv_pct;
		recv_pct = (idle_mode == IDLE_RECV) ? 62 : (idle_mode == IDLE_BOTH) ? 28 : 0;
		if (phase_id == PRESSURE_PHASE && !hold_done) begin
			out_ready <= 1'b0;
			if (hold_cycles == HOLD_LEN)
				hold_done <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_pct);
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t timeout: no word moved in %0d cycles", $time, quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic push_item(logic [kmp_pkg::OP_W-1:0] op, logic [kmp_pkg::CHAR_W-1:0] data);
		match_word_t w;
		w.op = op;
		w.data = data;
		pending_words.push_back(w);
		pushed_words++;
	endtask

	// Wait until every queued word is accepted and every result has come
	task automatic wait_drain();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	task automatic set_stop(int value);
		wait_drain();
		repeat (3) @(negedge clk);
		cfg_wdata <= value[kmp_pkg::COUNT_W-1:0];
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		stop_limit = value;
	endtask

	function automatic logic [kmp_pkg::CHAR_W-1:0] choose_sym(bit wide,
			logic [kmp_pkg::CHAR_W-1:0] a, logic [kmp_pkg::CHAR_W-1:0] b);
		if (wide)
			return kmp_pkg::CHAR_W'($urandom);
		return $urandom_range(0, 1) ? a : b;
	endfunction

	// Queue one sequence: mostly load a pattern and stream text, sometimes noise
	task automatic gen_sequence();
		logic [kmp_pkg::CHAR_W-1:0] sym_a, sym_b, b;
		logic [kmp_pkg::CHAR_W-1:0] pat_q [$];
		bit wide;
		int plen, tlen, pick;
		if ($urandom_range(0, 99) >= 85) begin
			repeat ($urandom_range(1, 8))
				push_item(kmp_pkg::OP_W'($urandom_range(0, 3)), kmp_pkg::CHAR_W'($urandom));
			return;
		end
		sym_a = kmp_pkg::CHAR_W'($urandom);
		sym_b = kmp_pkg::CHAR_W'($urandom);
		wide = ($urandom_range(0, 3) == 0);
		push_item(kmp_pkg::OP_CLEAR, kmp_pkg::CHAR_W'($urandom));
		if ($urandom_range(0, 19) == 0)
			plen = $urandom_range(60, kmp_pkg::MAX_PATTERN + 3);
		else
			plen = $urandom_range(1, 6);
		repeat (plen) begin
			b = choose_sym(wide, sym_a, sym_b);
			if (pat_q.size() < kmp_pkg::MAX_PATTERN)
				pat_q.push_back(b);
			push_item(kmp_pkg::OP_APPEND, b);
		end
		tlen = $urandom_range(8, 40);
		while (tlen > 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				// copy the pattern into the text so matches occur
				foreach (pat_q[j])
					push_item(kmp_pkg::OP_TEXT, pat_q[j]);
				if (stop_limit < 4 && $urandom_range(0, 1))
					push_item(kmp_pkg::OP_RESTART, kmp_pkg::CHAR_W'($urandom));
				tlen -= pat_q.size() + 1;
			end else if (pick < 38) begin
				push_item(kmp_pkg::OP_RESTART, kmp_pkg::CHAR_W'($urandom));
				tlen--;
			end else if (pick < 41) begin
				b = choose_sym(wide, sym_a, sym_b);
				if (pat_q.size() < kmp_pkg::MAX_PATTERN)
					pat_q.push_back(b);
				push_item(kmp_pkg::OP_APPEND, b);
				tlen--;
			end else if (pick < 45) begin
				push_item(kmp_pkg::OP_TEXT, kmp_pkg::CHAR_W'($urandom));
				tlen--;
			end else begin
				push_item(kmp_pkg::OP_TEXT, choose_sym(wide, sym_a, sym_b));
				tlen--;
			end
		end
	endtask

	task automatic run_phase(int id, int stop, idle_mode_t mode, int words, bit pauses);
		int target;
		set_stop(stop);
		@(posedge clk);
		phase_id = id;
		idle_mode = mode;
		target = pushed_words + words;
		while (pushed_words < target) begin
			gen_sequence();
			// let the sender pause until every result is back
			if (pauses && $urandom_range(0, 3) == 0)
				wait_drain();
		end
	endtask

	initial begin
		for (int i = 0; i < kmp_pkg::MAX_PATTERN; i++) begin
			pat_chars[i] = '0;
			fail_len[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pattern, overlapping hits, count reached, restart,
		// append during a search, clear, single-byte pattern
		push_item(kmp_pkg::OP_TEXT, 8'h00);
		push_item(kmp_pkg::OP_APPEND, 8'hFF);
		push_item(kmp_pkg::OP_APPEND, 8'h00);
		push_item(kmp_pkg::OP_APPEND, 8'hFF);
		push_item(kmp_pkg::OP_TEXT, 8'hFF);
		push_item(kmp_pkg::OP_TEXT, 8'h00);
		push_item(kmp_pkg::OP_TEXT, 8'hFF);
		push_item(kmp_pkg::OP_TEXT, 8'h00);
		push_item(kmp_pkg::OP_TEXT, 8'hFF);
		push_item(kmp_pkg::OP_TEXT, 8'hFF);
		push_item(kmp_pkg::OP_RESTART, 8'hAA);
		push_item(kmp_pkg::OP_TEXT, 8'hFF);
		push_item(kmp_pkg::OP_TEXT, 8'h00);
		push_item(kmp_pkg::OP_TEXT, 8'hFF);
		push_item(kmp_pkg::OP_APPEND, 8'h00);
		push_item(kmp_pkg::OP_TEXT, 8'h00);
		push_item(kmp_pkg::OP_TEXT, 8'h7F);
		push_item(kmp_pkg::OP_CLEAR, 8'hFF);
		push_item(kmp_pkg::OP_TEXT, 8'h55);
		push_item(kmp_pkg::OP_APPEND, 8'h80);
		push_item(kmp_pkg::OP_TEXT, 8'h80);
		push_item(kmp_pkg::OP_TEXT, 8'h80);
		push_item(kmp_pkg::OP_RESTART, 8'h00);

		run_phase(1, 255, IDLE_NONE, 400, 1'b0);
		run_phase(2, 1, IDLE_SEND, 350, 1'b0);
		run_phase(PRESSURE_PHASE, 3, IDLE_RECV, 350, 1'b0);
		run_phase(4, 0, IDLE_BOTH, 150, 1'b0);
		run_phase(5, 7, IDLE_BOTH, 350, 1'b1);
		run_phase(6, 255, IDLE_NONE, 350, 1'b0);

		wait_drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
design/kmp_pkg.sv
design/kmp_cell.sv
design/kmp_cell_row.sv
design/kmp_stream_matcher_top.sv
verif/kmp_stream_matcher_top_tb.sv
